[sv/ihm_pkg.sv]
// ihm_pkg: shared types, codes and constants of the interval histogram monitor.
// Used by ihm_divider, ihm_hist_ram, interval_histogram_monitor and tb_top.
// No dependencies.
package ihm_pkg;

	// Field widths fixed by the item format
	localparam int TIME_W     = 64;
	localparam int PERIOD_W   = 32;
	localparam int FRAMES_W   = 32;
	localparam int SEL_W      = 7;
	localparam int COUNT_W    = 64;
	localparam int OP_W       = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 64;

	// Histogram defaults; a bucket is one sixteenth of the period
	localparam int BUCKETS_DEF  = 128;
	localparam int SUBDIV_SHIFT = 4;

	// Serial divider geometry
	localparam int DIVIDEND_W = TIME_W;
	localparam int DIVISOR_W  = PERIOD_W;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

	// Operation codes
	localparam logic [OP_W-1:0] OP_CALLBACK = 2'd0;
	localparam logic [OP_W-1:0] OP_XRUN     = 2'd1;
	localparam logic [OP_W-1:0] OP_READ     = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_START  = 1'b1;

	typedef struct packed {
		logic [OP_W-1:0]     op;
		logic [TIME_W-1:0]   event_time;
		logic [FRAMES_W-1:0] missing_frames;
		logic [SEL_W-1:0]    bucket_select;
	} in_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] callback_total;
		logic [COUNT_W-1:0] interval_sum;
		logic [TIME_W-1:0]  interval_max;
		logic [COUNT_W-1:0] xrun_total;
		logic [COUNT_W-1:0] lost_frames_total;
		logic [TIME_W-1:0]  first_xrun_time;
		logic [TIME_W-1:0]  last_xrun_time;
		logic [SEL_W-1:0]   bucket_index;
		logic [COUNT_W-1:0] bucket_count;
		logic               interval_valid;
	} out_item_t;

	// Divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_START,
		ST_DIV,
		ST_RD,
		ST_DONE
	} state_t;

endpackage

[sv/ihm_divider.sv]
// ihm_divider: restoring divider, one quotient bit per cycle.
// 64-bit dividend by 32-bit divisor; done pulses when the quotient is ready.
// Depends on ihm_pkg.
module ihm_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ihm_pkg::DIVIDEND_W-1:0] dividend,
	input  logic [ihm_pkg::DIVISOR_W-1:0]  divisor,
	output logic [ihm_pkg::DIVIDEND_W-1:0] quotient,
	output ihm_pkg::div_status_t           status
);

	logic [ihm_pkg::DIVISOR_W-1:0]  rem_q;
	logic [ihm_pkg::DIVIDEND_W-1:0] quo_q;
	logic [ihm_pkg::DIVISOR_W-1:0]  div_q;
	logic [ihm_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic                           busy_q;
	logic                           done_q;

	logic [ihm_pkg::DIVISOR_W:0]    trial;
	logic                           ge;
	logic [ihm_pkg::DIVISOR_W-1:0]  rem_n;

	// One restoring step: shift in the next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, quo_q[ihm_pkg::DIVIDEND_W-1]};
		ge    = (trial >= {1'b0, div_q});
		rem_n = ge ? ihm_pkg::DIVISOR_W'(trial - {1'b0, div_q})
		           : trial[ihm_pkg::DIVISOR_W-1:0];
	end

	// Control: busy over the iterations, done pulse after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == ihm_pkg::DIV_CNT_W'(ihm_pkg::DIVIDEND_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend bits shift out of quo_q as quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_n;
			quo_q <= {quo_q[ihm_pkg::DIVIDEND_W-2:0], ge};
		end
	end

	assign quotient    = quo_q;
	assign status.busy = busy_q;
	assign status.done = done_q;

endmodule

[sv/ihm_hist_ram.sv]
// ihm_hist_ram: histogram count store, one write and one read port.
// Synchronous read, data registered in the cycle after rd_en. Depends on ihm_pkg.
module ihm_hist_ram #(
	parameter int DEPTH = ihm_pkg::BUCKETS_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [AW-1:0]               wr_addr,
	input  logic [ihm_pkg::COUNT_W-1:0] wr_data,
	input  logic                        rd_en,
	input  logic [AW-1:0]               rd_addr,
	output logic [ihm_pkg::COUNT_W-1:0] rd_data
);

	logic [ihm_pkg::COUNT_W-1:0] mem [DEPTH];
	logic [ihm_pkg::COUNT_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[sv/interval_histogram_monitor.sv]
// interval_histogram_monitor: callback interval statistics and histogram.
// Depends on ihm_pkg, ihm_divider, ihm_hist_ram.
//
//  channel | signals                         | direction | transfer when
//  --------+---------------------------------+-----------+---------------------
//  in      | in_valid, in_stall, in_data     | into      | in_valid && !in_stall
//  out     | out_valid, out_stall, out_data  | out of    | out_valid && !out_stall
//  cfg     | cfg_wr_en, cfg_index, cfg_data  | into      | cfg_wr_en
//
// One item at a time. A callback that needs a division goes through these steps:
// accept, divider start, 64 divider steps, done, histogram read, write-back.
// Other callbacks, xruns and reads skip the divider steps.
// After reset the histogram is cleared bucket by bucket; in_stall is high then.
// The result sits in an output register; a stalled output holds the next item
// in its last step until the register frees up.
module interval_histogram_monitor #(
	parameter int BUCKETS = ihm_pkg::BUCKETS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  ihm_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output ihm_pkg::out_item_t                out_data,
	input  logic                              cfg_wr_en,
	input  logic [ihm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ihm_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int AW = $clog2(BUCKETS);
	localparam logic [AW-1:0] LAST_BUCKET = AW'(BUCKETS - 1);

	ihm_pkg::state_t state_q, state_n;

	// Configuration
	logic [ihm_pkg::PERIOD_W-1:0] period_q;
	logic [ihm_pkg::TIME_W-1:0]   start_q;

	// Running statistics
	logic [ihm_pkg::TIME_W-1:0]  prev_q;
	logic [ihm_pkg::COUNT_W-1:0] cnt_q;
	logic [ihm_pkg::COUNT_W-1:0] sum_q;
	logic [ihm_pkg::TIME_W-1:0]  max_q;
	logic [ihm_pkg::COUNT_W-1:0] xrun_q;
	logic [ihm_pkg::COUNT_W-1:0] lost_q;
	logic [ihm_pkg::TIME_W-1:0]  first_q;
	logic [ihm_pkg::TIME_W-1:0]  last_q;

	// Item in flight
	ihm_pkg::in_item_t           item_q;
	logic [ihm_pkg::TIME_W-1:0]  interval_q;
	logic [AW-1:0]               bucket_q;
	logic                        meas_q;
	logic                        read_hit_q;
	logic [AW-1:0]               clr_addr_q;

	// Output register
	logic                        out_valid_q;
	ihm_pkg::out_item_t          out_q;

	// Control
	logic                        accept;
	logic                        out_load;
	logic                        out_free;
	logic                        div_start;
	logic                        rd_en;
	logic                        wr_en;
	logic [AW-1:0]               wr_addr;
	logic [ihm_pkg::COUNT_W-1:0] wr_data;
	logic [ihm_pkg::COUNT_W-1:0] rd_data;
	logic [ihm_pkg::DIVIDEND_W-1:0] quotient;
	ihm_pkg::div_status_t        div_st;

	logic [ihm_pkg::TIME_W-1:0]  in_interval;
	logic                        in_meas;
	logic                        sel_hit;
	ihm_pkg::out_item_t          res;
	logic [ihm_pkg::TIME_W-1:0]  elapsed;
	logic [ihm_pkg::COUNT_W-1:0] xrun_n;
	logic [ihm_pkg::COUNT_W-1:0] bucket_inc;
	logic [AW-1:0]               div_bucket;

	assign out_free    = !out_valid_q || !out_stall;
	assign in_interval = in_data.event_time - prev_q;
	assign in_meas     = (in_data.op == ihm_pkg::OP_CALLBACK) && (prev_q != '0);
	assign sel_hit     = 32'(in_data.bucket_select) < 32'(BUCKETS);
	assign div_bucket  = (quotient >= ihm_pkg::DIVIDEND_W'(BUCKETS)) ? LAST_BUCKET
	                                                                 : quotient[AW-1:0];

	// Sequencer: next state and strobes
	always_comb begin
		state_n   = state_q;
		in_stall  = 1'b1;
		accept    = 1'b0;
		div_start = 1'b0;
		rd_en     = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			ihm_pkg::ST_CLEAR: begin
				if (clr_addr_q == LAST_BUCKET) begin
					state_n = ihm_pkg::ST_IDLE;
				end
			end
			ihm_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				accept   = in_valid;
				if (in_valid) begin
					priority if (in_meas) begin
						if (period_q == '0 || in_interval[ihm_pkg::TIME_W-1 -:
						    ihm_pkg::SUBDIV_SHIFT] != '0) begin
							state_n = ihm_pkg::ST_RD;
						end else begin
							state_n = ihm_pkg::ST_START;
						end
					end else if (in_data.op == ihm_pkg::OP_READ && sel_hit) begin
						state_n = ihm_pkg::ST_RD;
					end else begin
						state_n = ihm_pkg::ST_DONE;
					end
				end
			end
			ihm_pkg::ST_START: begin
				div_start = 1'b1;
				state_n   = ihm_pkg::ST_DIV;
			end
			ihm_pkg::ST_DIV: begin
				if (div_st.done) begin
					state_n = ihm_pkg::ST_RD;
				end
			end
			ihm_pkg::ST_RD: begin
				rd_en   = 1'b1;
				state_n = ihm_pkg::ST_DONE;
			end
			ihm_pkg::ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_n  = ihm_pkg::ST_IDLE;
				end
			end
			default: begin
				state_n = ihm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ihm_pkg::ST_CLEAR;
		end else begin
			state_q <= state_n;
		end
	end

	// Clearing pass address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (state_q == ihm_pkg::ST_CLEAR) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= '0;
			start_q  <= '0;
		end else if (cfg_wr_en) begin
			if (cfg_index == ihm_pkg::CFG_PERIOD) begin
				period_q <= cfg_data[ihm_pkg::PERIOD_W-1:0];
			end else begin
				start_q <= cfg_data;
			end
		end
	end

	// Item capture and bucket selection
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q     <= in_data;
			interval_q <= in_interval;
			meas_q     <= in_meas;
			read_hit_q <= sel_hit;
			priority if (in_meas) begin
				bucket_q <= (period_q == '0) ? '0 : LAST_BUCKET;
			end else begin
				bucket_q <= AW'(in_data.bucket_select);
			end
		end else if (state_q == ihm_pkg::ST_DIV && div_st.done) begin
			bucket_q <= div_bucket;
		end
	end

	ihm_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({interval_q[ihm_pkg::TIME_W-1-ihm_pkg::SUBDIV_SHIFT:0],
		            {ihm_pkg::SUBDIV_SHIFT{1'b0}}}),
		.divisor  (period_q),
		.quotient (quotient),
		.status   (div_st)
	);

	// Histogram write: clearing pass, then read-modify-write on commit
	assign bucket_inc = rd_data + 1'b1;
	assign wr_en   = (state_q == ihm_pkg::ST_CLEAR) || (out_load && meas_q);
	assign wr_addr = (state_q == ihm_pkg::ST_CLEAR) ? clr_addr_q : bucket_q;
	assign wr_data = (state_q == ihm_pkg::ST_CLEAR) ? '0 : bucket_inc;

	ihm_hist_ram #(
		.DEPTH (BUCKETS),
		.AW    (AW)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (bucket_q),
		.rd_data (rd_data)
	);

	// Result and updated totals
	always_comb begin
		elapsed = item_q.event_time - start_q;
		xrun_n  = xrun_q + 1'b1;
		res.callback_total    = cnt_q;
		res.interval_sum      = sum_q;
		res.interval_max      = max_q;
		res.xrun_total        = xrun_q;
		res.lost_frames_total = lost_q;
		res.first_xrun_time   = first_q;
		res.last_xrun_time    = last_q;
		res.bucket_index      = '0;
		res.bucket_count      = '0;
		res.interval_valid    = 1'b0;
		if (meas_q) begin
			res.callback_total = cnt_q + 1'b1;
			res.interval_sum   = sum_q + interval_q;
			res.interval_max   = (interval_q > max_q) ? interval_q : max_q;
			res.bucket_index   = ihm_pkg::SEL_W'(bucket_q);
			res.bucket_count   = bucket_inc;
			res.interval_valid = 1'b1;
		end else if (item_q.op == ihm_pkg::OP_XRUN) begin
			res.xrun_total        = xrun_n;
			res.lost_frames_total = lost_q + ihm_pkg::COUNT_W'(item_q.missing_frames);
			res.first_xrun_time   = (xrun_n == ihm_pkg::COUNT_W'(1)) ? elapsed : first_q;
			res.last_xrun_time    = elapsed;
		end else if (item_q.op == ihm_pkg::OP_READ) begin
			res.bucket_index = item_q.bucket_select;
			res.bucket_count = read_hit_q ? rd_data : '0;
		end
	end

	// Commit statistics with the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= '0;
			cnt_q   <= '0;
			sum_q   <= '0;
			max_q   <= '0;
			xrun_q  <= '0;
			lost_q  <= '0;
			first_q <= '0;
			last_q  <= '0;
		end else if (out_load) begin
			if (item_q.op == ihm_pkg::OP_CALLBACK) begin
				prev_q <= item_q.event_time;
			end
			cnt_q   <= res.callback_total;
			sum_q   <= res.interval_sum;
			max_q   <= res.interval_max;
			xrun_q  <= res.xrun_total;
			lost_q  <= res.lost_frames_total;
			first_q <= res.first_xrun_time;
			last_q  <= res.last_xrun_time;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Checks
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_st.done |-> state_q == ihm_pkg::ST_DIV)
		else $error("divider finished outside the divide state");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_st.busy)
		else $error("divider started while busy");

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ihm_pkg::ST_DONE))
		else $error("result raised outside the commit step");

	a_rd_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> 32'(bucket_q) < 32'(BUCKETS))
		else $error("histogram read beyond the last bucket");

	a_wr_meas_only: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && state_q != ihm_pkg::ST_CLEAR) |-> $past(rd_en) || $past(state_q ==
		ihm_pkg::ST_DONE))
		else $error("histogram write without a preceding read");

endmodule

[sim/tb_top.sv]
// tb_top: self-checking bench for interval_histogram_monitor.
// Keeps its own model of the interval statistics and histogram, and compares every result.
// Depends on ihm_pkg and the interval_histogram_monitor RTL.
`timescale 1ns / 1ps

module tb_top;
	import ihm_pkg::*;

	localparam int BUCKETS        = BUCKETS_DEF;
	localparam int LONG_HOLD      = 400;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES  = 80;
	localparam int MAX_PRINTED    = 30;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	out_item_t             out_data;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = CFG_PERIOD;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow copy of the block's registers and statistics
	logic [PERIOD_W-1:0] period_cfg = '0;
	logic [TIME_W-1:0]   origin_cfg = '0;
	logic [TIME_W-1:0]   last_stamp = '0;
	logic [COUNT_W-1:0]  n_intervals = '0;
	logic [COUNT_W-1:0]  sum_ns = '0;
	logic [TIME_W-1:0]   max_ns = '0;
	logic [COUNT_W-1:0]  n_xruns = '0;
	logic [COUNT_W-1:0]  frames_lost = '0;
	logic [TIME_W-1:0]   xrun_early_gap = '0;
	logic [TIME_W-1:0]   xrun_late_gap = '0;
	logic [COUNT_W-1:0]  bucket_hist [BUCKETS];

	out_item_t expected_stats_q [$];

	// Stimulus control; idle_enable and hold_request are shared with the stall process
	logic [TIME_W-1:0] stamp_cursor = 64'd1000;
	bit                idle_enable = 1'b0;
	bit                hold_request = 1'b0;

	// Run bookkeeping
	int mismatches = 0;
	int results_checked = 0;
	int items_seen = 0;
	int cb_seen = 0;
	int top_bucket_hits = 0;
	int xrun_seen = 0;
	int read_seen = 0;
	int unused_seen = 0;
	int reg_writes = 0;

	interval_histogram_monitor #(.BUCKETS(BUCKETS)) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Histogram bucket for one interval: sixteenths of the period, clamped
	function automatic int unsigned bucket_of(input logic [TIME_W-1:0] gap_ns);
		logic [TIME_W+3:0] scaled;
		logic [TIME_W+3:0] quot;
		if (period_cfg == '0)
			return 0;
		scaled = {gap_ns, 4'b0000};
		quot = scaled / {36'd0, period_cfg};
		if (quot >= BUCKETS)
			return BUCKETS - 1;
		return int'(quot);
	endfunction

	// Apply one accepted item to the shadow statistics; return the expected result
	function automatic out_item_t update_stats(input in_item_t item);
		out_item_t   res;
		logic [63:0] held;
		logic [63:0] gap_ns;
		logic [63:0] elapsed;
		int unsigned b;
		res = '0;
		items_seen++;
		case (item.op)
			OP_CALLBACK: begin
				cb_seen++;
				held = last_stamp;
				last_stamp = item.event_time;
				// zero stamp means no earlier callback held
				if (held != '0) begin
					gap_ns = item.event_time - held;
					n_intervals++;
					sum_ns += gap_ns;
					if (gap_ns > max_ns)
						max_ns = gap_ns;
					b = bucket_of(gap_ns);
					if (b == BUCKETS - 1)
						top_bucket_hits++;
					bucket_hist[b]++;
					res.bucket_index = SEL_W'(b);
					res.bucket_count = bucket_hist[b];
					res.interval_valid = 1'b1;
				end
			end
			OP_XRUN: begin
				xrun_seen++;
				elapsed = item.event_time - origin_cfg;
				n_xruns++;
				frames_lost += {32'd0, item.missing_frames};
				if (n_xruns == 64'd1)
					xrun_early_gap = elapsed;
				xrun_late_gap = elapsed;
			end
			OP_READ: begin
				read_seen++;
				res.bucket_index = item.bucket_select;
				if (int'(item.bucket_select) < BUCKETS)
					res.bucket_count = bucket_hist[item.bucket_select];
			end
			default: begin
				unused_seen++;
			end
		endcase
		res.callback_total = n_intervals;
		res.interval_sum = sum_ns;
		res.interval_max = max_ns;
		res.xrun_total = n_xruns;
		res.lost_frames_total = frames_lost;
		res.first_xrun_time = xrun_early_gap;
		res.last_xrun_time = xrun_late_gap;
		return res;
	endfunction

	// Random item: mostly a coherent callback stream, with noise mixed in
	function automatic in_item_t compose_item();
		in_item_t    item;
		int unsigned pick;
		logic [63:0] step;
		item.op = OP_READ;
		item.event_time = {$urandom, $urandom};
		item.missing_frames = $urandom;
		item.bucket_select = SEL_W'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 60) begin
			item.op = OP_CALLBACK;
			if ($urandom_range(0, 9) != 0) begin
				if (period_cfg == '0)
					step = 64'($urandom_range(0, 5000));
				else
					step = ((64'(period_cfg) * 64'($urandom_range(0, 140))) >> 4)
						+ 64'($urandom_range(0, period_cfg >> 4));
				stamp_cursor += step;
				item.event_time = stamp_cursor;
			end else begin
				case ($urandom_range(0, 3))
					0: item.event_time = '0;
					1: item.event_time = {$urandom, $urandom};
					2: item.event_time = stamp_cursor - 64'($urandom_range(1, 1000));
					default: item.event_time = stamp_cursor + {$urandom, $urandom};
				endcase
				stamp_cursor = item.event_time;
			end
		end else if (pick < 75) begin
			item.op = OP_XRUN;
			if ($urandom_range(0, 4) != 0)
				item.event_time = stamp_cursor + 64'($urandom_range(0, 999));
		end else if (pick >= 95) begin
			item.op = OP_UNUSED;
		end
		return item;
	endfunction

	task automatic flag_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatches < MAX_PRINTED)
			$display("tb_top: mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// One input transfer; valid stays high so a following item goes out back to back
	task automatic send_item(input in_item_t item);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data <= item;
		do @(posedge clk); while (in_stall !== 1'b0);
		expected_stats_q.push_back(update_stats(item));
	endtask

	task automatic release_input();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Random sender gap, only when idle_enable is set
	task automatic sender_gap();
		int n;
		if (idle_enable && $urandom_range(0, 3) == 0) begin
			n = $urandom_range(1, 18);
			release_input();
			repeat (n - 1) @(negedge clk);
		end
	endtask

	// Hold off input until every expected result has arrived
	task automatic drain();
		release_input();
		while (expected_stats_q.size() != 0)
			@(posedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == CFG_PERIOD)
			period_cfg = value[PERIOD_W-1:0];
		else
			origin_cfg = value;
		reg_writes++;
	endtask

	function automatic in_item_t make_item(input logic [OP_W-1:0] op,
		input logic [63:0] stamp, input logic [31:0] frames, input logic [SEL_W-1:0] sel);
		in_item_t item;
		item.op = op;
		item.event_time = stamp;
		item.missing_frames = frames;
		item.bucket_select = sel;
		return item;
	endfunction

	// Callbacks: first and zero stamps, exact bucket, clamp, backward and huge intervals
	task automatic test_callback_cases();
		write_register(CFG_PERIOD, 64'd1000);
		write_register(CFG_START, 64'd500);
		send_item(make_item(OP_CALLBACK, 64'd0, 32'd0, 7'd0));
		send_item(make_item(OP_CALLBACK, 64'd0, 32'd0, 7'd0));
		send_item(make_item(OP_CALLBACK, 64'd1000, 32'd0, 7'd0));
		send_item(make_item(OP_CALLBACK, 64'd2000, 32'd0, 7'd0));
		send_item(make_item(OP_CALLBACK, 64'd2000, 32'd0, 7'd0));
		send_item(make_item(OP_CALLBACK, 64'd10000, 32'd0, 7'd0));
		send_item(make_item(OP_CALLBACK, 64'd11062, 32'd0, 7'd0));
		send_item(make_item(OP_CALLBACK, 64'd5, 32'd0, 7'd0));
		send_item(make_item(OP_CALLBACK, '1, '1, '1));
		send_item(make_item(OP_CALLBACK, 64'h0FFF_FFFF_FFFF_FFFF, 32'd0, 7'd0));
	endtask

	// Xruns: elapsed time wrapping below the start, full frame count, zero elapsed
	task automatic test_xrun_cases();
		send_item(make_item(OP_XRUN, 64'd400, '1, 7'd0));
		send_item(make_item(OP_XRUN, '1, 32'd0, '1));
		send_item(make_item(OP_XRUN, 64'd500, 32'd1, 7'd0));
	endtask

	// Bucket reads at both ends and an empty one, plus the unused op
	task automatic test_read_and_unused();
		send_item(make_item(OP_READ, 64'd0, 32'd0, 7'd0));
		send_item(make_item(OP_READ, 64'd0, 32'd0, 7'd16));
		send_item(make_item(OP_READ, 64'd0, 32'd0, 7'd127));
		send_item(make_item(OP_READ, '1, '1, 7'd64));
		send_item(make_item(OP_UNUSED, '1, '1, '1));
		send_item(make_item(OP_UNUSED, 64'd0, 32'd0, 7'd0));
	endtask

	// Zero period puts everything in bucket 0; full-scale period and start extremes
	task automatic test_period_extremes();
		drain();
		write_register(CFG_PERIOD, 64'd0);
		write_register(CFG_START, '1);
		send_item(make_item(OP_CALLBACK, 64'd1, 32'd0, 7'd0));
		send_item(make_item(OP_CALLBACK, 64'd1_000_000_000, 32'd0, 7'd0));
		send_item(make_item(OP_XRUN, 64'd0, 32'd7, 7'd0));
		drain();
		write_register(CFG_PERIOD, '1);
		write_register(CFG_START, 64'd0);
		send_item(make_item(OP_CALLBACK, 64'd1_000_000_000 + 64'hFFFF_FFFF, 32'd0, 7'd0));
		send_item(make_item(OP_XRUN, 64'd12345, 32'd3, 7'd0));
		send_item(make_item(OP_READ, 64'd0, 32'd0, 7'd16));
	endtask

	// Random traffic over several period and start settings, with idling on both sides
	task automatic test_random_traffic();
		logic [31:0] period_set [6];
		logic [63:0] origin;
		period_set = '{32'd1_000_000, 32'd1, 32'd0, 32'hFFFF_FFFF,
			$urandom_range(16, 1 << 20), 32'd48_000};
		idle_enable = 1'b1;
		for (int ph = 0; ph < 6; ph++) begin
			drain();
			case (ph)
				1: origin = '0;
				2: origin = '1;
				3: origin = stamp_cursor - 64'($urandom_range(0, 100000));
				default: origin = {$urandom, $urandom};
			endcase
			// upper bits of a period write are ignored
			write_register(CFG_PERIOD, {$urandom, period_set[ph]});
			write_register(CFG_START, origin);
			repeat (180) begin
				send_item(compose_item());
				sender_gap();
			end
		end
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering
	task automatic test_output_backpressure();
		drain();
		hold_request = 1'b1;
		repeat (16)
			send_item(compose_item());
		drain();
	endtask

	// Sender pauses until everything is back, then carries on
	task automatic test_drain_pause();
		repeat (2) begin
			repeat (40) begin
				send_item(compose_item());
				sender_gap();
			end
			drain();
		end
	endtask

	// Closing stretch with no idling at all
	task automatic test_steady_tail();
		idle_enable = 1'b0;
		write_register(CFG_PERIOD, 64'd250_000);
		write_register(CFG_START, stamp_cursor);
		repeat (150)
			send_item(compose_item());
	endtask

	// Receiver stall: long hold when asked, else random bursts
	always @(negedge clk) begin : stall_driver
		int hold_left;
		int stall_left;
		int ready_left;
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = LONG_HOLD;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (ready_left != 0) begin
			ready_left--;
			out_stall <= 1'b0;
		end else begin
			out_stall <= 1'b0;
			if (idle_enable && $urandom_range(0, 2) == 0)
				stall_left = $urandom_range(1, 18);
			else
				ready_left = $urandom_range(0, 30);
		end
	end

	// Result checker
	always @(posedge clk) begin : result_check
		out_item_t want;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (expected_stats_q.size() == 0) begin
				flag_mismatch("result with nothing expected", 64'd0, 64'd0);
			end else begin
				want = expected_stats_q.pop_front();
				results_checked++;
				if (out_data.callback_total !== want.callback_total)
					flag_mismatch("callback_total", out_data.callback_total, want.callback_total);
				if (out_data.interval_sum !== want.interval_sum)
					flag_mismatch("interval_sum", out_data.interval_sum, want.interval_sum);
				if (out_data.interval_max !== want.interval_max)
					flag_mismatch("interval_max", out_data.interval_max, want.interval_max);
				if (out_data.xrun_total !== want.xrun_total)
					flag_mismatch("xrun_total", out_data.xrun_total, want.xrun_total);
				if (out_data.lost_frames_total !== want.lost_frames_total)
					flag_mismatch("lost_frames_total", out_data.lost_frames_total,
						want.lost_frames_total);
				if (out_data.first_xrun_time !== want.first_xrun_time)
					flag_mismatch("first_xrun_time", out_data.first_xrun_time,
						want.first_xrun_time);
				if (out_data.last_xrun_time !== want.last_xrun_time)
					flag_mismatch("last_xrun_time", out_data.last_xrun_time, want.last_xrun_time);
				if (out_data.bucket_index !== want.bucket_index)
					flag_mismatch("bucket_index", 64'(out_data.bucket_index),
						64'(want.bucket_index));
				if (out_data.bucket_count !== want.bucket_count)
					flag_mismatch("bucket_count", out_data.bucket_count, want.bucket_count);
				if (out_data.interval_valid !== want.interval_valid)
					flag_mismatch("interval_valid", 64'(out_data.interval_valid),
						64'(want.interval_valid));
			end
		end
	end

	// Watchdog on cycles with no transfer on either channel
	always @(posedge clk) begin : watchdog
		int quiet_cycles;
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: no transfer for %0d cycles", quiet_cycles);
			$display("tb_top NOT OK");
			$finish;
		end
	end

	initial begin
		for (int i = 0; i < BUCKETS; i++)
			bucket_hist[i] = '0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		// histogram clear pass runs with input stalled
		do @(posedge clk); while (in_stall !== 1'b0);

		test_callback_cases();
		test_xrun_cases();
		test_read_and_unused();
		test_period_extremes();
		test_random_traffic();
		test_output_backpressure();
		test_drain_pause();
		test_steady_tail();

		release_input();
		while (expected_stats_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_stats_q.size() != 0)
			flag_mismatch("results still outstanding", 64'(expected_stats_q.size()), 64'd0);

		$display("tb_top: %0d items, %0d results checked, %0d register writes, %0d mismatches",
			items_seen, results_checked, reg_writes, mismatches);
		$display("tb_top: %0d callbacks (%0d intervals, %0d in top bucket), %0d xruns,",
			cb_seen, n_intervals, top_bucket_hits, xrun_seen);
		$display("tb_top: %0d reads, %0d unused op", read_seen, unused_seen);
		if (mismatches == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

[filelist.f]
sv/ihm_pkg.sv
sv/ihm_divider.sv
sv/ihm_hist_ram.sv
sv/interval_histogram_monitor.sv
sim/tb_top.sv
